// ----- sv/clbs_pkg.sv -----
// ----------------------------------------------------------------------------
// clbs_pkg: shared types and constants of the character LCD bus sequencer
// Holds the request codes, the sequence kinds, the step actions and the
// table of steps that every sequence walks through.
// ----------------------------------------------------------------------------
package clbs_pkg;

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 2;
  localparam int COLUMN_W = 6;
  localparam int TPM_W    = 16;
  localparam int MS_W     = 6;
  localparam int STEP_W   = 5;

  // Request codes on the input channel.
  localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INIT     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_WR_CMD   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WR_DATA  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_GOTO     = 3'd5;

  localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd1;
  localparam logic [ROW_W-1:0] ROW_SECOND = 2'd2;

  localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;

  // Controller command bytes.
  localparam logic [BYTE_W-1:0] LCD_FUNCTION_SET = 8'h3C;
  localparam logic [BYTE_W-1:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [BYTE_W-1:0] LCD_CLEAR        = 8'h01;
  localparam logic [BYTE_W-1:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [BYTE_W-1:0] LCD_ROW1_BASE    = 8'd127;
  localparam logic [BYTE_W-1:0] LCD_ROW2_BASE    = 8'd191;

  typedef enum logic [2:0] {
    KIND_IDLE      = 3'd0,
    KIND_INIT      = 3'd1,
    KIND_CMD       = 3'd2,
    KIND_DATA      = 3'd3,
    KIND_CLEAR     = 3'd4,
    KIND_GOTO      = 3'd5,
    KIND_WAIT_ONLY = 3'd6
  } seq_kind_t;

  typedef enum logic [2:0] {
    ACT_END      = 3'd0,
    ACT_HI_CONST = 3'd1,
    ACT_HI_PEND  = 3'd2,
    ACT_LO       = 3'd3,
    ACT_WAIT     = 3'd4
  } step_act_t;

  typedef struct packed {
    step_act_t         act;
    logic [BYTE_W-1:0] arg;
  } step_entry_t;

  // One step of a sequence: the action and its byte or millisecond count.
  function automatic step_entry_t seq_entry(seq_kind_t kind, logic [STEP_W-1:0] idx,
                                            logic [MS_W-1:0] pow_ms);
    step_entry_t e;
    e.act = ACT_END;
    e.arg = '0;
    case (kind)
      KIND_INIT: begin
        case (idx)
          5'd0:  begin e.act = ACT_WAIT;     e.arg = {2'b00, pow_ms};  end
          5'd1:  begin e.act = ACT_HI_CONST; e.arg = LCD_FUNCTION_SET; end
          5'd2:  begin e.act = ACT_LO;                                 end
          5'd3:  begin e.act = ACT_WAIT;     e.arg = 8'd1;             end
          5'd4:  begin e.act = ACT_HI_CONST; e.arg = LCD_DISPLAY_ON;   end
          5'd5:  begin e.act = ACT_LO;                                 end
          5'd6:  begin e.act = ACT_WAIT;     e.arg = 8'd1;             end
          5'd7:  begin e.act = ACT_HI_CONST; e.arg = LCD_CLEAR;        end
          5'd8:  begin e.act = ACT_LO;                                 end
          5'd9:  begin e.act = ACT_WAIT;     e.arg = 8'd2;             end
          5'd10: begin e.act = ACT_HI_CONST; e.arg = LCD_ENTRY_MODE;   end
          5'd11: begin e.act = ACT_LO;                                 end
          default: e.act = ACT_END;
        endcase
      end
      KIND_CMD, KIND_DATA: begin
        case (idx)
          5'd0:    e.act = ACT_HI_PEND;
          5'd1:    e.act = ACT_LO;
          default: e.act = ACT_END;
        endcase
      end
      KIND_CLEAR: begin
        case (idx)
          5'd0:    begin e.act = ACT_HI_CONST; e.arg = LCD_CLEAR; end
          5'd1:    e.act = ACT_LO;
          5'd2:    begin e.act = ACT_WAIT; e.arg = 8'd2; end
          default: e.act = ACT_END;
        endcase
      end
      KIND_GOTO: begin
        case (idx)
          5'd0:    e.act = ACT_HI_PEND;
          5'd1:    e.act = ACT_LO;
          5'd2:    begin e.act = ACT_WAIT; e.arg = 8'd1; end
          default: e.act = ACT_END;
        endcase
      end
      KIND_WAIT_ONLY: begin
        case (idx)
          5'd0:    begin e.act = ACT_WAIT; e.arg = 8'd1; end
          default: e.act = ACT_END;
        endcase
      end
      default: e.act = ACT_END;
    endcase
    return e;
  endfunction

endpackage

// ----- sv/clbs_req_if.sv -----
// ----------------------------------------------------------------------------
// clbs_req_if: request channel of the character LCD bus sequencer
// Valid/ready handshake carrying one tick or one LCD request.
// ----------------------------------------------------------------------------
interface clbs_req_if;
  logic                             valid;
  logic                             ready;
  logic [clbs_pkg::OPCODE_W-1:0]    opcode;
  logic [clbs_pkg::BYTE_W-1:0]      byte_value;
  logic [clbs_pkg::ROW_W-1:0]       row;
  logic [clbs_pkg::COLUMN_W-1:0]    column;

  modport source (output valid, opcode, byte_value, row, column, input ready);
  modport sink   (input valid, opcode, byte_value, row, column, output ready);
endinterface

// ----- sv/clbs_res_if.sv -----
// ----------------------------------------------------------------------------
// clbs_res_if: result channel of the character LCD bus sequencer
// Valid/ready handshake carrying the pin levels after one request.
// ----------------------------------------------------------------------------
interface clbs_res_if;
  logic                         valid;
  logic                         ready;
  logic                         rs_pin;
  logic                         rw_pin;
  logic                         enable_pin;
  logic [clbs_pkg::BYTE_W-1:0]  data_bus;
  logic                         busy_res;
  logic                         rejected;

  modport source (output valid, rs_pin, rw_pin, enable_pin, data_bus, busy_res, rejected,
                  input ready);
  modport sink   (input valid, rs_pin, rw_pin, enable_pin, data_bus, busy_res, rejected,
                  output ready);
endinterface

// ----- sv/char_lcd_bus_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: 8-bit character LCD bus driver
// Sequences RS, RW, E and the data bus for init, byte writes, clear and
// cursor positioning, timed by tick requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_ch (valid/ready). Opcode tick advances time by one
// tick; init, write command, write data, clear and go to position start a
// pin sequence whose first action shows in the result of that same request.
// Every accepted request yields exactly one result on out_ch, giving the
// pin levels after that request plus busy and rejected flags. An init,
// write, clear or go-to request arriving while a sequence runs is
// dropped and flagged as rejected. cfg_we/cfg_wdata set ticks_per_ms (zero
// acts as one) and should only be written while the sequencer is idle.
// The result is registered; one request is taken every cycle while
// in_ch.ready is high. The result register is the only buffer, so
// in_ch.ready drops exactly while a result is held and out_ch.ready is
// low; the sequencer state then freezes until the receiver takes the result.
// Reset clears all pins low, returns to idle and loads ticks_per_ms = 1000.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer #(
  parameter int POWER_ON_WAIT_MS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  clbs_req_if.sink                      in_ch,
  clbs_res_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [clbs_pkg::TPM_W-1:0]    cfg_wdata
);

  localparam logic [clbs_pkg::MS_W-1:0] POW_MS = clbs_pkg::MS_W'(POWER_ON_WAIT_MS);

  // Sequencer state.
  clbs_pkg::seq_kind_t              kind_r, kind_nxt;
  logic [clbs_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [clbs_pkg::TPM_W-1:0]       tick_r, tick_nxt;
  logic [clbs_pkg::MS_W-1:0]        ms_r, ms_nxt;
  logic [clbs_pkg::BYTE_W-1:0]      pend_r, pend_nxt;
  logic                             rs_r, rs_nxt;
  logic                             en_r, en_nxt;
  logic [clbs_pkg::BYTE_W-1:0]      bus_r, bus_nxt;
  logic                             rejected_r, rejected_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [clbs_pkg::TPM_W-1:0]       tpm_r;

  logic                             in_ready;
  logic                             in_acc;
  logic                             busy;
  logic                             is_req;
  logic [clbs_pkg::TPM_W-1:0]       limit;
  logic [clbs_pkg::TPM_W-1:0]       tick_p1;
  logic [clbs_pkg::MS_W-1:0]        ms_dec;

  // Step entry request produced by the tick or request path.
  logic                             do_enter;
  clbs_pkg::seq_kind_t              ent_kind;
  logic [clbs_pkg::STEP_W-1:0]      ent_idx;
  logic [clbs_pkg::BYTE_W-1:0]      ent_pend;
  logic [clbs_pkg::TPM_W-1:0]       pre_tick;
  logic [clbs_pkg::MS_W-1:0]        pre_ms;
  logic [clbs_pkg::STEP_W-1:0]      pre_step;

  clbs_pkg::step_entry_t            e0, e1, ent;
  logic [clbs_pkg::STEP_W-1:0]      ent_idx_skip;
  logic                             skip_wait;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ready;
  assign busy     = (kind_r != clbs_pkg::KIND_IDLE);
  assign is_req   = (in_ch.opcode == clbs_pkg::OP_INIT) ||
                    (in_ch.opcode == clbs_pkg::OP_WR_CMD) ||
                    (in_ch.opcode == clbs_pkg::OP_WR_DATA) ||
                    (in_ch.opcode == clbs_pkg::OP_CLEAR) ||
                    (in_ch.opcode == clbs_pkg::OP_GOTO);
  assign limit    = (tpm_r == '0) ? clbs_pkg::TPM_W'(1) : tpm_r;
  assign tick_p1  = tick_r + clbs_pkg::TPM_W'(1);
  assign ms_dec   = ms_r - clbs_pkg::MS_W'(1);

  // Decide what this request does: count a tick, start a sequence or reject.
  always_comb begin
    do_enter     = 1'b0;
    ent_kind     = kind_r;
    ent_idx      = step_r;
    ent_pend     = pend_r;
    pre_tick     = tick_r;
    pre_ms       = ms_r;
    pre_step     = step_r;
    rejected_nxt = 1'b0;
    if (in_ch.opcode == clbs_pkg::OP_TICK) begin
      if (busy) begin
        if ((tick_p1 >= limit) || (tick_p1 == '0)) begin
          // Millisecond boundary: count down and move on when the step expires.
          pre_tick = '0;
          pre_ms   = ms_dec;
          if (ms_dec == '0) begin
            do_enter = 1'b1;
            ent_idx  = step_r + clbs_pkg::STEP_W'(1);
          end
        end else begin
          pre_tick = tick_p1;
        end
      end
    end else if (is_req) begin
      if (busy) begin
        rejected_nxt = 1'b1;
      end else begin
        do_enter = 1'b1;
        ent_idx  = '0;
        pre_tick = '0;
        ent_kind = clbs_pkg::seq_kind_t'(in_ch.opcode);
        if ((in_ch.opcode == clbs_pkg::OP_WR_CMD) ||
            (in_ch.opcode == clbs_pkg::OP_WR_DATA)) begin
          ent_pend = in_ch.byte_value;
        end else if (in_ch.opcode == clbs_pkg::OP_GOTO) begin
          if (in_ch.row == clbs_pkg::ROW_FIRST) begin
            ent_pend = clbs_pkg::LCD_ROW1_BASE + {2'b00, in_ch.column};
          end else if (in_ch.row == clbs_pkg::ROW_SECOND) begin
            ent_pend = clbs_pkg::LCD_ROW2_BASE + {2'b00, in_ch.column};
          end else begin
            ent_kind = clbs_pkg::KIND_WAIT_ONLY;
          end
        end
      end
    end
  end

  // Step table lookup. A wait of zero milliseconds is skipped; the table never
  // holds two waits in a row, so one look-ahead entry is enough.
  always_comb begin
    e0           = clbs_pkg::seq_entry(ent_kind, ent_idx, POW_MS);
    ent_idx_skip = ent_idx + clbs_pkg::STEP_W'(1);
    e1           = clbs_pkg::seq_entry(ent_kind, ent_idx_skip, POW_MS);
    skip_wait    = (e0.act == clbs_pkg::ACT_WAIT) && (e0.arg[clbs_pkg::MS_W-1:0] == '0);
    ent          = skip_wait ? e1 : e0;
  end

  // Next state: apply the entry action of the new step.
  always_comb begin
    kind_nxt = kind_r;
    step_nxt = pre_step;
    tick_nxt = pre_tick;
    ms_nxt   = pre_ms;
    pend_nxt = ent_pend;
    rs_nxt   = rs_r;
    en_nxt   = en_r;
    bus_nxt  = bus_r;
    if (do_enter) begin
      kind_nxt = ent_kind;
      step_nxt = skip_wait ? ent_idx_skip : ent_idx;
      unique case (ent.act)
        clbs_pkg::ACT_HI_CONST, clbs_pkg::ACT_HI_PEND: begin
          rs_nxt  = (ent_kind == clbs_pkg::KIND_DATA);
          bus_nxt = (ent.act == clbs_pkg::ACT_HI_CONST) ? ent.arg : ent_pend;
          en_nxt  = 1'b1;
          ms_nxt  = clbs_pkg::MS_W'(1);
        end
        clbs_pkg::ACT_LO: begin
          en_nxt = 1'b0;
          ms_nxt = clbs_pkg::MS_W'(1);
        end
        clbs_pkg::ACT_WAIT: begin
          ms_nxt = ent.arg[clbs_pkg::MS_W-1:0];
        end
        default: begin
          kind_nxt = clbs_pkg::KIND_IDLE;
          step_nxt = '0;
          ms_nxt   = '0;
          tick_nxt = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= clbs_pkg::KIND_IDLE;
      step_r      <= '0;
      tick_r      <= '0;
      ms_r        <= '0;
      pend_r      <= '0;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      bus_r       <= '0;
      rejected_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tpm_r       <= clbs_pkg::TPM_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tpm_r <= cfg_wdata;
      end
      if (in_acc) begin
        kind_r     <= kind_nxt;
        step_r     <= step_nxt;
        tick_r     <= tick_nxt;
        ms_r       <= ms_nxt;
        pend_r     <= pend_nxt;
        rs_r       <= rs_nxt;
        en_r       <= en_nxt;
        bus_r      <= bus_nxt;
        rejected_r <= rejected_nxt;
      end
    end
  end

  // The state registers only move when a request is accepted, so the result
  // fields read the pin state directly.
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.rs_pin     = rs_r;
  assign out_ch.rw_pin     = 1'b0;
  assign out_ch.enable_pin = en_r;
  assign out_ch.data_bus   = bus_r;
  assign out_ch.busy_res   = busy;
  assign out_ch.rejected   = rejected_r;

  // A running sequence always has a step with time left.
  a_busy_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (ms_r != '0))
    else $error("sequence running with no milliseconds left");

  // E is only high inside a sequence.
  a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |-> busy)
    else $error("enable high while idle");

  // A request arriving during a sequence is rejected and leaves the pins alone.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && busy && is_req) |=> (rejected_r && $stable(bus_r) && $stable(en_r) && busy))
    else $error("request during busy not rejected");

  // A tick while idle changes nothing on the pins.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !busy && (in_ch.opcode == clbs_pkg::OP_TICK)) |=>
      (!busy && !rejected_r && $stable(bus_r) && $stable(rs_r)))
    else $error("idle tick disturbed the pins");

endmodule
